// File: rtl/sliding_window_reorder_receiver_defines.svh
// Assertion macros for the sliding window reorder receiver checker
`ifndef SLIDING_WINDOW_REORDER_RECEIVER_DEFINES_SVH
`define SLIDING_WINDOW_REORDER_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SWRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver window check failed");

// Next-cycle implication, sampled on clk, off during reset
`define SWRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver window check failed");

`endif

// File: rtl/swrr_pkg.sv
// Shared types, constants and helpers of the sliding window reorder receiver
package swrr_pkg;

    localparam int WINDOW_DEPTH  = 16;
    localparam int PAYLOAD_BYTES = 1024;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WIN_W = 5;
    localparam int SEQ_W = 32;
    localparam int LEN_W = 11;
    localparam int HDL_W = 16;
    localparam int TOT_W = 32;

    // Packet kinds on req_type
    typedef enum logic [1:0] {
        PKT_START = 2'd0,
        PKT_END   = 2'd1,
        PKT_DATA  = 2'd2,
        PKT_RSVD  = 2'd3
    } pkt_kind_t;

    // Result kinds on result_kind
    localparam logic RES_ACK     = 1'b0;
    localparam logic RES_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic REG_WINDOW_SLOTS = 1'b0;
    localparam logic REG_ACK_MODE     = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } swrr_state_t;

    // Contents of one window slot
    typedef struct packed {
        logic             filled;
        logic [LEN_W-1:0] length;
        logic [HDL_W-1:0] handle;
    } swrr_slot_t;

    // Control broadcast to every slot cell
    typedef struct packed {
        logic             load;
        logic             shift;
        logic [IDX_W-1:0] index;
        logic [LEN_W-1:0] length;
        logic [HDL_W-1:0] handle;
    } swrr_cell_ctrl_t;

    // Add a byte count to the running total, stick at all ones
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] total,
                                                 input logic [LEN_W-1:0] len);
        logic [TOT_W:0] sum;
        sum = {1'b0, total} + (TOT_W+1)'(len);
        return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
    endfunction

endpackage

// File: rtl/sliding_window_reorder_receiver.sv
// An ack for start, end, old or parked data is on the result ports in the cycle
// after its item is taken; the first release of an in-order run passes the state
// and result registers, then one a cycle. Busy stays low for those acks.
// Data at the expected number: busy until its ack is formed, one release a cycle
// from the bottom slot cell as the cell row shifts down, then the ack.
// Reset (async, active low) empties all slots and clears counters at once.
module sliding_window_reorder_receiver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [swrr_pkg::SEQ_W-1:0]   seq_num,
    input  logic [swrr_pkg::LEN_W-1:0]   payload_length,
    input  logic [swrr_pkg::HDL_W-1:0]   payload_handle,
    input  logic                         wr_en,
    input  logic                         wr_index,
    input  logic [swrr_pkg::WIN_W-1:0]   wr_data,
    output logic                         result_valid,
    output logic                         result_kind,
    output logic [swrr_pkg::SEQ_W-1:0]   ack_seq,
    output logic [swrr_pkg::HDL_W-1:0]   release_handle,
    output logic [swrr_pkg::LEN_W-1:0]   release_length,
    output logic [swrr_pkg::TOT_W-1:0]   bytes_delivered,
    output logic                         session_done,
    output logic                         last
);
    import swrr_pkg::*;

    // Configuration
    logic [WIN_W-1:0] window_slots_reg;
    logic             ack_mode_reg;

    // Control state
    swrr_state_t      state_reg, state_next;
    logic [SEQ_W-1:0] expected_reg, expected_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [WIN_W-1:0] rel_cnt_reg, rel_cnt_next;
    logic [SEQ_W-1:0] seq_hold_reg, seq_hold_next;

    // Result register
    logic             res_valid_reg, res_valid_next;
    logic             res_kind_reg, res_kind_next;
    logic [SEQ_W-1:0] res_seq_reg, res_seq_next;
    logic [HDL_W-1:0] res_handle_reg, res_handle_next;
    logic [LEN_W-1:0] res_length_reg, res_length_next;
    logic [TOT_W-1:0] res_total_reg, res_total_next;
    logic             res_done_reg, res_done_next;
    logic             res_last_reg, res_last_next;

    swrr_cell_ctrl_t  ctrl;
    swrr_slot_t       slot_q [WINDOW_DEPTH];

    logic             accept;
    logic [WIN_W-1:0] win_eff;
    logic [LEN_W-1:0] len_sat;
    logic [SEQ_W-1:0] offset;
    logic             release_go;
    logic [SEQ_W-1:0] ack_value;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Clamp the configured window to 1..WINDOW_DEPTH
    always_comb
    begin
        if (window_slots_reg == '0)
            win_eff = WIN_W'(1);
        else if (32'(window_slots_reg) > 32'(WINDOW_DEPTH))
            win_eff = WIN_W'(WINDOW_DEPTH);
        else
            win_eff = window_slots_reg;
    end

    assign len_sat = (32'(payload_length) > 32'(PAYLOAD_BYTES))
                   ? LEN_W'(PAYLOAD_BYTES) : payload_length;
    assign offset  = seq_num - expected_reg;

    // Keep releasing while the bottom cell is filled and inside the window
    assign release_go = slot_q[0].filled && (rel_cnt_reg < win_eff);

    // Ack number at the end of a release run
    assign ack_value = ack_mode_reg ? seq_hold_reg : expected_reg;

    // Slot cell row, the top cell takes an empty slot on a shift
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        swrr_slot_t upper;
        if (i == WINDOW_DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = slot_q[i+1];
        end
        swrr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .ctrl       (ctrl),
            .upper      (upper),
            .slot       (slot_q[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == PKT_DATA) && (seq_num == expected_reg)
                    && (len_sat != '0))
                    state_next = ST_RELEASE;
            end
            ST_RELEASE:
            begin
                if (!release_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result control
    always_comb
    begin
        ctrl            = '0;
        expected_next   = expected_reg;
        total_next      = total_reg;
        rel_cnt_next    = rel_cnt_reg;
        seq_hold_next   = seq_hold_reg;
        res_valid_next  = 1'b0;
        res_kind_next   = RES_ACK;
        res_seq_next    = res_seq_reg;
        res_handle_next = '0;
        res_length_next = '0;
        res_total_next  = total_reg;
        res_done_next   = 1'b0;
        res_last_next   = 1'b1;
        ctrl.length     = len_sat;
        ctrl.handle     = payload_handle;
        ctrl.index      = offset[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        PKT_START, PKT_END:
                        begin
                            // Echo the packet number, flag an end at the expected number
                            res_valid_next = 1'b1;
                            res_seq_next   = seq_num;
                            res_done_next  = (req_type == PKT_END)
                                          && (seq_num == expected_reg);
                        end
                        PKT_DATA:
                        begin
                            if (seq_num > expected_reg)
                            begin
                                // Park inside the window, drop beyond it or when empty
                                if ((offset < SEQ_W'(win_eff)) && (len_sat != '0))
                                begin
                                    ctrl.load      = 1'b1;
                                    res_valid_next = 1'b1;
                                    res_seq_next   = ack_mode_reg ? seq_num : expected_reg;
                                end
                            end
                            else if (seq_num == expected_reg)
                            begin
                                // Fill the bottom cell and start the release run
                                if (len_sat != '0)
                                begin
                                    ctrl.load     = 1'b1;
                                    rel_cnt_next  = '0;
                                    seq_hold_next = seq_num;
                                end
                            end
                            else
                            begin
                                // Old data: acknowledge only
                                res_valid_next = 1'b1;
                                res_seq_next   = ack_mode_reg ? seq_num : expected_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RELEASE:
            begin
                res_valid_next = 1'b1;
                if (release_go)
                begin
                    // Release the bottom cell and shift the row down
                    ctrl.shift      = 1'b1;
                    total_next      = sat_add(total_reg, slot_q[0].length);
                    expected_next   = expected_reg + SEQ_W'(1);
                    rel_cnt_next    = rel_cnt_reg + WIN_W'(1);
                    res_kind_next   = RES_RELEASE;
                    res_seq_next    = expected_reg;
                    res_handle_next = slot_q[0].handle;
                    res_length_next = slot_q[0].length;
                    res_total_next  = total_next;
                    res_last_next   = 1'b0;
                end
                else
                begin
                    res_seq_next = ack_value;
                end
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_slots_reg <= WIN_W'(16);
            ack_mode_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WINDOW_SLOTS: window_slots_reg <= wr_data;
                REG_ACK_MODE:     ack_mode_reg     <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expected_reg  <= '0;
            total_reg     <= '0;
            rel_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            total_reg     <= total_next;
            rel_cnt_reg   <= rel_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload and held packet number
    always_ff @(posedge clk)
    begin
        seq_hold_reg   <= seq_hold_next;
        res_kind_reg   <= res_kind_next;
        res_seq_reg    <= res_seq_next;
        res_handle_reg <= res_handle_next;
        res_length_reg <= res_length_next;
        res_total_reg  <= res_total_next;
        res_done_reg   <= res_done_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid    = res_valid_reg;
    assign result_kind     = res_kind_reg;
    assign ack_seq         = res_seq_reg;
    assign release_handle  = res_handle_reg;
    assign release_length  = res_length_reg;
    assign bytes_delivered = res_total_reg;
    assign session_done    = res_done_reg;
    assign last            = res_last_reg;

endmodule

// File: rtl/swrr_cell.sv
// One window slot: loads a parked packet or takes its upper neighbor on a shift
module swrr_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [swrr_pkg::IDX_W-1:0]      cell_index,
    input  swrr_pkg::swrr_cell_ctrl_t       ctrl,
    input  swrr_pkg::swrr_slot_t            upper,
    output swrr_pkg::swrr_slot_t            slot
);
    import swrr_pkg::*;

    logic             filled_reg;
    logic [LEN_W-1:0] length_reg;
    logic [HDL_W-1:0] handle_reg;
    logic             hit;

    assign hit = ctrl.load && (ctrl.index == cell_index);

    // Load on a matching park, otherwise advance from the neighbor on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            length_reg <= '0;
        end
        else if (hit)
        begin
            filled_reg <= 1'b1;
            length_reg <= ctrl.length;
        end
        else if (ctrl.shift)
        begin
            filled_reg <= upper.filled;
            length_reg <= upper.length;
        end
    end

    // Handle is only read from a filled slot, so it needs no reset
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            handle_reg <= ctrl.handle;
        end
        else if (ctrl.shift)
        begin
            handle_reg <= upper.handle;
        end
    end

    assign slot = '{filled: filled_reg, length: length_reg, handle: handle_reg};

endmodule

// File: rtl/swrr_checker.sv
// Port-level checks of the sliding window reorder receiver, bound to the top level
`include "sliding_window_reorder_receiver_defines.svh"

module swrr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   req_type,
    input logic [swrr_pkg::SEQ_W-1:0]   seq_num,
    input logic                         result_valid,
    input logic                         result_kind,
    input logic [swrr_pkg::SEQ_W-1:0]   ack_seq,
    input logic                         session_done,
    input logic                         last
);
    import swrr_pkg::*;

    logic rel_now;
    logic start_taken;

    assign rel_now     = result_valid && (result_kind == RES_RELEASE);
    assign start_taken = start && !busy && (req_type == PKT_START);

    // The final result of an item is always its ack
    `SWRR_ASSERT_NOW(a_last_is_ack, result_valid && last, result_kind == RES_ACK)

    // A release never ends the item and never flags the session end
    `SWRR_ASSERT_NOW(a_release_not_final, rel_now, !last && !session_done)

    // A release is always followed by another result in the next cycle
    `SWRR_ASSERT_NEXT(a_release_continues, rel_now, result_valid)

    // A start packet is acknowledged in the next cycle with its own number
    `SWRR_ASSERT_NEXT(a_start_ack, start_taken, result_valid && last && ack_seq == $past(seq_num))

    // Back-to-back releases carry consecutive numbers
    `SWRR_ASSERT_NOW(a_release_order, rel_now && $past(rel_now), ack_seq == $past(ack_seq) + 32'd1)

endmodule

bind sliding_window_reorder_receiver swrr_checker u_swrr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .seq_num      (seq_num),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .ack_seq      (ack_seq),
    .session_done (session_done),
    .last         (last)
);

// File: tb/testbench.sv
// Self-checking testbench for the sliding window reorder receiver
`timescale 1ns / 100ps

module testbench;
    import swrr_pkg::*;

    localparam int ITEM_QUOTA  = 420;
    localparam int PHASE_ITEMS = 64;
    localparam int REPORT_MAX  = 10;

    // One result item as it should leave the block
    typedef struct {
        logic             kind;
        logic [SEQ_W-1:0] seq;
        logic [HDL_W-1:0] handle;
        logic [LEN_W-1:0] length;
        logic [TOT_W-1:0] total;
        logic             done;
        logic             last;
    } delivery_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       req_type;
    logic [SEQ_W-1:0] seq_num;
    logic [LEN_W-1:0] payload_length;
    logic [HDL_W-1:0] payload_handle;
    logic             wr_en;
    logic             wr_index;
    logic [WIN_W-1:0] wr_data;
    logic             result_valid;
    logic             result_kind;
    logic [SEQ_W-1:0] ack_seq;
    logic [HDL_W-1:0] release_handle;
    logic [LEN_W-1:0] release_length;
    logic [TOT_W-1:0] bytes_delivered;
    logic             session_done;
    logic             last;

    // Shadow copy of the receiver window and its registers
    logic [WIN_W-1:0] win_cfg;
    logic             echo_mode;
    logic [SEQ_W-1:0] next_seq;
    logic             slot_full [WINDOW_DEPTH];
    logic [LEN_W-1:0] slot_len [WINDOW_DEPTH];
    logic [HDL_W-1:0] slot_hdl [WINDOW_DEPTH];
    logic [TOT_W-1:0] delivered;

    delivery_t awaited_deliveries[$];

    int errors       = 0;
    int packets_sent = 0;
    int releases     = 0;
    int acks         = 0;
    int sessions     = 0;
    int longest_run  = 0;

    sliding_window_reorder_receiver DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .seq_num         (seq_num),
        .payload_length  (payload_length),
        .payload_handle  (payload_handle),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .ack_seq         (ack_seq),
        .release_handle  (release_handle),
        .release_length  (release_length),
        .bytes_delivered (bytes_delivered),
        .session_done    (session_done),
        .last            (last)
    );

    always #10 clk = ~clk;

    // Slots in use after clamping the register value
    function automatic int unsigned active_slots();
        if (win_cfg == '0)
            return 1;
        if (win_cfg > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return win_cfg;
    endfunction

    // Queue one expected result, stamped with the running byte total
    function automatic void owe_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                       input logic [HDL_W-1:0] hdl,
                                       input logic [LEN_W-1:0] len,
                                       input logic done, input logic fin);
        delivery_t d;
        d.kind   = kind;
        d.seq    = seq;
        d.handle = hdl;
        d.length = len;
        d.total  = delivered;
        d.done   = done;
        d.last   = fin;
        awaited_deliveries.push_back(d);
    endfunction

    // Update the shadow window for one accepted packet and queue its results
    function automatic void window_receive(input pkt_kind_t kind,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [LEN_W-1:0] len_in,
                                           input logic [HDL_W-1:0] hdl);
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] offset;
        logic [TOT_W-1:0] room;
        int unsigned      win;
        int unsigned      run;
        int unsigned      i;
        len    = (len_in > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : len_in;
        win    = active_slots();
        offset = seq - next_seq;
        case (kind)
            PKT_START, PKT_END:
                owe_result(RES_ACK, seq, '0, '0,
                           (kind == PKT_END) && (seq == next_seq), 1'b1);
            PKT_DATA:
                if (seq > next_seq) begin
                    // park inside the window, drop beyond it or when empty
                    if (offset < win && len != '0) begin
                        slot_full[offset] = 1'b1;
                        slot_len[offset]  = len;
                        slot_hdl[offset]  = hdl;
                        owe_result(RES_ACK, echo_mode ? seq : next_seq, '0, '0, 1'b0, 1'b1);
                    end
                end else if (seq == next_seq) begin
                    if (len != '0) begin
                        slot_full[0] = 1'b1;
                        slot_len[0]  = len;
                        slot_hdl[0]  = hdl;
                        run = 0;
                        while (run < win && slot_full[run])
                            run++;
                        // release the filled run in order
                        for (i = 0; i < run; i++) begin
                            room = '1 - delivered;
                            delivered += (TOT_W'(slot_len[i]) < room) ?
                                         TOT_W'(slot_len[i]) : room;
                            owe_result(RES_RELEASE, next_seq + i, slot_hdl[i], slot_len[i],
                                       1'b0, 1'b0);
                        end
                        // shift the window down by the run
                        for (i = 0; i < WINDOW_DEPTH; i++) begin
                            if (i + run < WINDOW_DEPTH) begin
                                slot_full[i] = slot_full[i + run];
                                slot_len[i]  = slot_len[i + run];
                                slot_hdl[i]  = slot_hdl[i + run];
                            end else begin
                                slot_full[i] = 1'b0;
                                slot_len[i]  = '0;
                                slot_hdl[i]  = '0;
                            end
                        end
                        next_seq += run;
                        if (run > longest_run)
                            longest_run = run;
                        owe_result(RES_ACK, echo_mode ? seq : next_seq, '0, '0, 1'b0, 1'b1);
                    end
                end else begin
                    // old data is only acknowledged
                    owe_result(RES_ACK, echo_mode ? seq : next_seq, '0, '0, 1'b0, 1'b1);
                end
            default: ;
        endcase
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Offer one packet and hold it until the block takes it
    task automatic send_packet(input pkt_kind_t kind, input logic [SEQ_W-1:0] seq,
                               input logic [LEN_W-1:0] len, input logic [HDL_W-1:0] hdl);
        start          <= 1'b1;
        req_type       <= kind;
        seq_num        <= seq;
        payload_length <= len;
        payload_handle <= hdl;
        do
            @(posedge clk);
        while (busy);
        packets_sent++;
        window_receive(kind, seq, len, hdl);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold off until every expected result has come and the block is idle
    task automatic wait_drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (awaited_deliveries.size() != 0);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [WIN_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_WINDOW_SLOTS)
            win_cfg = value;
        else
            echo_mode = value[0];
        @(posedge clk);
    endtask

    // Packet kinds, field extremes and the drop and ignore cases
    task automatic test_packet_kinds();
        send_packet(PKT_START, 32'd0, 11'd0, 16'h0000);
        send_packet(PKT_DATA, 32'd0, 11'd100, 16'hFFFF);
        send_packet(PKT_DATA, 32'd3, 11'h7FF, 16'h0000);
        send_packet(PKT_DATA, 32'd3, 11'd1025, 16'h1234);
        send_packet(PKT_DATA, 32'd2, 11'd0, 16'h5555);
        send_packet(PKT_DATA, 32'd1, 11'd0, 16'h5555);
        send_packet(PKT_DATA, 32'd17, 11'd7, 16'h0F0F);
        send_packet(PKT_DATA, 32'hFFFF_FFFF, 11'd7, 16'hF0F0);
        send_packet(PKT_DATA, 32'd0, 11'd50, 16'h00FF);
        send_packet(PKT_RSVD, 32'hAAAA_5555, 11'h555, 16'hAAAA);
        send_packet(PKT_DATA, 32'd1, 11'd1024, 16'hBEEF);
        send_packet(PKT_DATA, 32'd2, 11'd1, 16'hAAAA);
        send_packet(PKT_END, 32'd99, 11'h2AA, 16'h5555);
        send_packet(PKT_END, 32'd4, 11'd0, 16'h0000);
        send_packet(PKT_DATA, 32'd4, 11'd9, 16'h1357);
        wait_drain();
    endtask

    // Window clamping, echo mode, a full window and a shrunk window
    task automatic test_window_config();
        int unsigned k;
        write_reg(REG_ACK_MODE, 5'd1);
        write_reg(REG_WINDOW_SLOTS, 5'd0);
        send_packet(PKT_DATA, next_seq + 1, 11'd10, 16'h0001);
        send_packet(PKT_DATA, next_seq, 11'd10, 16'h0002);
        send_packet(PKT_DATA, next_seq - 2, 11'd10, 16'h0003);
        wait_drain();
        // fill every slot, then release all of them in one burst
        write_reg(REG_WINDOW_SLOTS, 5'd31);
        for (k = 1; k < WINDOW_DEPTH; k++)
            send_packet(PKT_DATA, next_seq + k, $urandom_range(1, PAYLOAD_BYTES),
                        HDL_W'($urandom));
        send_packet(PKT_DATA, next_seq, 11'd1024, 16'hFFFF);
        wait_drain();
        // park ahead, then shrink so the release run stops at the window edge
        write_reg(REG_WINDOW_SLOTS, 5'd16);
        for (k = 1; k <= 4; k++)
            send_packet(PKT_DATA, next_seq + k, 11'(k * 3), HDL_W'(16'hC000 + k));
        wait_drain();
        write_reg(REG_WINDOW_SLOTS, 5'd2);
        send_packet(PKT_DATA, next_seq, 11'd5, 16'hC000);
        send_packet(PKT_DATA, next_seq, 11'd6, 16'hC005);
        wait_drain();
        write_reg(REG_WINDOW_SLOTS, 5'd16);
        write_reg(REG_ACK_MODE, 5'd0);
    endtask

    // Random traffic, mostly in-window data, in phases of fixed settings
    task automatic test_random_traffic();
        logic [WIN_W-1:0] win_plan [6];
        logic             mode_plan [6];
        pkt_kind_t        kind;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [HDL_W-1:0] hdl;
        int unsigned      pick;
        int unsigned      win;
        int               phase;
        win_plan  = '{5'd16, 5'd1, 5'd0, 5'd31, WIN_W'($urandom), WIN_W'($urandom)};
        mode_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom), 1'($urandom)};
        for (phase = 0; phase < 6; phase++) begin
            wait_drain();
            write_reg(REG_WINDOW_SLOTS, win_plan[phase]);
            write_reg(REG_ACK_MODE, {4'd0, mode_plan[phase]});
            while (packets_sent < ITEM_QUOTA - (5 - phase) * PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                win  = active_slots();
                kind = PKT_DATA;
                hdl  = HDL_W'($urandom);
                len  = $urandom_range(1, PAYLOAD_BYTES);
                if ($urandom_range(0, 15) == 0)
                    len = LEN_W'($urandom);
                if (pick < 30)
                    seq = next_seq;
                else if (pick < 72)
                    seq = next_seq + $urandom_range(1, win);
                else if (pick < 80)
                    seq = (next_seq >= 8) ? next_seq - $urandom_range(1, 8) : $urandom;
                else if (pick < 86) begin
                    kind = PKT_START;
                    seq  = $urandom_range(0, 1) ? next_seq : $urandom;
                end else if (pick < 92) begin
                    kind = PKT_END;
                    seq  = $urandom_range(0, 1) ? next_seq : $urandom;
                end else if (pick < 95) begin
                    kind = PKT_RSVD;
                    seq  = $urandom;
                end else begin
                    seq = $urandom;
                    len = LEN_W'($urandom);
                end
                send_packet(kind, seq, len, hdl);
                // no idling in the final phase
                if (phase < 5 && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 5));
            end
        end
        wait_drain();
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        delivery_t want;
        if (rst_n && result_valid) begin
            if (awaited_deliveries.size() == 0) begin
                note_failure($sformatf("unexpected result kind=%0d seq=%0h",
                                       result_kind, ack_seq));
            end else begin
                want = awaited_deliveries.pop_front();
                if (result_kind !== want.kind || ack_seq !== want.seq ||
                    release_handle !== want.handle || release_length !== want.length ||
                    bytes_delivered !== want.total || session_done !== want.done ||
                    last !== want.last)
                    note_failure($sformatf(
                        {"exp k=%0d s=%0h h=%0h l=%0d t=%0d d=%0d f=%0d ",
                         "got k=%0d s=%0h h=%0h l=%0d t=%0d d=%0d f=%0d"},
                        want.kind, want.seq, want.handle, want.length, want.total,
                        want.done, want.last, result_kind, ack_seq, release_handle,
                        release_length, bytes_delivered, session_done, last));
                if (want.kind == RES_RELEASE)
                    releases++;
                else
                    acks++;
                if (want.done)
                    sessions++;
            end
        end
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        req_type       <= PKT_START;
        seq_num        <= '0;
        payload_length <= '0;
        payload_handle <= '0;
        wr_en          <= 1'b0;
        wr_index       <= REG_WINDOW_SLOTS;
        wr_data        <= '0;
        win_cfg   = 5'd16;
        echo_mode = 1'b0;
        next_seq  = '0;
        delivered = '0;
        foreach (slot_full[i]) begin
            slot_full[i] = 1'b0;
            slot_len[i]  = '0;
            slot_hdl[i]  = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_packet_kinds();
        test_window_config();
        test_random_traffic();

        repeat (10) @(posedge clk);
        if (awaited_deliveries.size() != 0)
            note_failure($sformatf("%0d results never arrived", awaited_deliveries.size()));
        $display("Run covered %0d packets: %0d releases, %0d acks, %0d session ends",
                 packets_sent, releases, acks, sessions);
        $display("Longest in-order burst %0d slots, final expected number %0d",
                 longest_run, next_seq);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/swrr_pkg.sv
rtl/swrr_cell.sv
rtl/sliding_window_reorder_receiver.sv
rtl/swrr_checker.sv
tb/testbench.sv
